/* design/rbno_pkg.sv */
// Shared types and constants of the row block nonzero offset builder.
// Used by the channel interfaces and every module of the block; no dependencies.

package rbno_pkg;

   // Field widths of the channels
   localparam int ROW_INDEX_WIDTH  = 20;
   localparam int OFFSET_WIDTH     = 32;
   localparam int BLOCK_ROWS_WIDTH = 16;
   localparam int ROW_COUNT_WIDTH  = 21;
   localparam int CSR_INDEX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH   = 32;

   // Sizing of the datapath
   localparam int ROW_WIDTH   = 20;
   localparam int COUNT_WIDTH = 32;
   localparam int MAX_BLOCKS  = 63;

   // Entry index runs 0..MAX_BLOCKS+1
   localparam int BLK_IDX_WIDTH = $clog2(MAX_BLOCKS + 2);

   // Boundary values: row + 1, row count, and (MAX_BLOCKS+1) steps of block_rows, plus margin
   localparam int BW_ROW   = ROW_WIDTH + 1;
   localparam int BW_SPAN  = (BW_ROW > ROW_COUNT_WIDTH) ? BW_ROW : ROW_COUNT_WIDTH;
   localparam int BW_STEP  = BLOCK_ROWS_WIDTH + BLK_IDX_WIDTH;
   localparam int BOUND_WIDTH = ((BW_SPAN > BW_STEP) ? BW_SPAN : BW_STEP) + 1;

   // Queue between front and back
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_ROWS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_COUNT  = CSR_INDEX_WIDTH'(1);

   // One classified nonzero, as queued for the back end
   typedef struct packed {
      logic [ROW_WIDTH-1:0]   row;
      logic                   fin;
      logic [BOUND_WIDTH-1:0] span;
   } item_type;

   // Configuration as seen by front and back
   typedef struct packed {
      logic [BLOCK_ROWS_WIDTH-1:0] block_rows;          // never zero
      logic [ROW_COUNT_WIDTH-1:0]  row_count;
      logic                        block_rows_written;  // one-cycle pulse
   } cfg_type;

endpackage

/* design/rbno_if.sv */
// Channel interfaces of the row block nonzero offset builder: input, result, register write.
// Depends on rbno_pkg.

interface rbno_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [rbno_pkg::ROW_INDEX_WIDTH-1:0]  row_index;
   logic                                  final_nonzero;

   modport source (output valid, output row_index, output final_nonzero, input ready);
   modport sink   (input valid, input row_index, input final_nonzero, output ready);
endinterface

interface rbno_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rbno_pkg::OFFSET_WIDTH-1:0]  block_offset;
   logic                               run_end;
   logic                               overflow;

   modport source (output valid, output block_offset, output run_end, output overflow,
                   input ready);
   modport sink   (input valid, input block_offset, input run_end, input overflow,
                   output ready);
endinterface

interface rbno_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [rbno_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [rbno_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/rbno_front.sv */
// Front end: accepts nonzero beats, trims the row and works out the row span for the queue.
// Depends on rbno_pkg and rbno_if.

module rbno_front (
   rbno_req_if.sink                req_ch,
   input  rbno_pkg::cfg_type       cfg,
   input  logic                    q_full,
   output logic                    q_push,
   output rbno_pkg::item_type      q_item
);

   logic [rbno_pkg::ROW_WIDTH-1:0]   row;
   logic [rbno_pkg::BOUND_WIDTH-1:0] row_next;
   logic [rbno_pkg::BOUND_WIDTH-1:0] rows_cfg;

   // Take a beat whenever the queue has room
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   // Keep the low row bits; span covers the configured rows and this row
   assign row      = rbno_pkg::ROW_WIDTH'(req_ch.row_index);
   assign row_next = rbno_pkg::BOUND_WIDTH'(row) + rbno_pkg::BOUND_WIDTH'(1);
   assign rows_cfg = rbno_pkg::BOUND_WIDTH'(cfg.row_count);

   assign q_item.row  = row;
   assign q_item.fin  = req_ch.final_nonzero;
   assign q_item.span = (rows_cfg > row_next) ? rows_cfg : row_next;

endmodule

/* design/rbno_queue.sv */
// Short queue of classified nonzeros between front and back end.
// Depends on rbno_pkg.

module rbno_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rbno_pkg::item_type    push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output rbno_pkg::item_type    head
);

   rbno_pkg::item_type                   entries_ff [rbno_pkg::QUEUE_DEPTH];
   logic [rbno_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [rbno_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [rbno_pkg::QUEUE_PTR_WIDTH:0]   count_ff;

   assign full      = (count_ff == (rbno_pkg::QUEUE_PTR_WIDTH+1)'(rbno_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   // Store a pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + rbno_pkg::QUEUE_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + rbno_pkg::QUEUE_PTR_WIDTH'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (rbno_pkg::QUEUE_PTR_WIDTH+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (rbno_pkg::QUEUE_PTR_WIDTH+1)'(1);
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (rbno_pkg::QUEUE_PTR_WIDTH+1)'(rbno_pkg::QUEUE_DEPTH))
      else $error("queue fill level beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule

/* design/rbno_back.sv */
// Back end: steps the block boundary per queued nonzero and emits offset entries.
// Depends on rbno_pkg and rbno_if.

module rbno_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rbno_pkg::cfg_type     cfg,
   input  logic                  q_not_empty,
   input  rbno_pkg::item_type    q_head,
   output logic                  q_pop,
   rbno_rsp_if.source            rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOW,
      S_HIGH,
      S_TAIL
   } state_type;

   localparam int BW = rbno_pkg::BOUND_WIDTH;
   localparam int NW = rbno_pkg::BLK_IDX_WIDTH;
   localparam int CW = rbno_pkg::COUNT_WIDTH;
   localparam int OW = rbno_pkg::OFFSET_WIDTH;

   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NW-1:0]        nb_ff, nb_in;
   logic [BW-1:0]        nbfr_ff, nbfr_in;
   logic                 ovf_ff, ovf_in;
   logic [BW-1:0]        bound_ff, bound_in;
   logic                 bound_ok_ff, bound_ok_in;
   rbno_pkg::item_type   item_ff, item_in;
   logic                 step_ovf_ff, step_ovf_in;
   logic                 emitted_ff, emitted_in;
   logic                 out_valid_ff, out_valid_in;
   logic [OW-1:0]        out_offset_ff, out_offset_in;
   logic                 out_run_end_ff, out_run_end_in;
   logic                 out_overflow_ff, out_overflow_in;

   logic [BW-1:0]        br;
   logic [NW-1:0]        remain;
   logic [BW-1:0]        prod;
   logic [BW-1:0]        head_row;
   logic [BW-1:0]        item_row;
   logic                 p1_any;
   logic                 p1_ovf;
   logic                 p2_ovf;
   logic                 high_go;
   logic                 out_free;
   logic                 finish;

   assign br       = BW'(cfg.block_rows);
   assign out_free = !out_valid_ff || rsp_ch.ready;

   // Boundary of entry MAX_BLOCKS+1, reached from the current boundary in whole blocks
   assign remain = NW'(rbno_pkg::MAX_BLOCKS + 1) - nb_ff;
   assign prod   = BW'(remain) * br;

   // Predict overflow of this nonzero before any entry leaves
   assign head_row = BW'(q_head.row);
   assign p1_any   = head_row >= nbfr_ff;
   assign p1_ovf   = head_row >= bound_ff;
   assign p2_ovf   = q_head.fin && !p1_ovf && (p1_any || (nbfr_ff >= br))
                     && ((bound_ff - br) < q_head.span);

   assign item_row = BW'(item_ff.row);
   assign high_go  = (nbfr_ff >= br) && ((nbfr_ff - br) < item_ff.span);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      nb_in           = nb_ff;
      nbfr_in         = nbfr_ff;
      ovf_in          = ovf_ff;
      bound_in        = bound_ff;
      bound_ok_in     = bound_ok_ff;
      item_in         = item_ff;
      step_ovf_in     = step_ovf_ff;
      emitted_in      = emitted_ff;
      out_valid_in    = out_valid_ff && !rsp_ch.ready;
      out_offset_in   = out_offset_ff;
      out_run_end_in  = out_run_end_ff;
      out_overflow_in = out_overflow_ff;
      q_pop           = 1'b0;
      finish          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!bound_ok_ff) begin
               // Refresh the overflow boundary after reset, a new block size or a new run
               bound_in    = nbfr_ff + prod;
               bound_ok_in = 1'b1;
            end else if (q_not_empty) begin
               q_pop = 1'b1;
               if (ovf_ff) begin
                  // Overflowed run: count only
                  cnt_in = cnt_ff + CW'(1);
                  finish = q_head.fin;
               end else if (!p1_any && !q_head.fin) begin
                  // Same block, nothing to emit
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  item_in     = q_head;
                  step_ovf_in = p1_ovf || p2_ovf;
                  emitted_in  = 1'b0;
                  state_in    = S_LOW;
               end
            end
         end
         S_LOW: begin
            // Entries whose boundary this row has reached
            if (item_row >= nbfr_ff) begin
               if (nb_ff > NW'(rbno_pkg::MAX_BLOCKS)) begin
                  ovf_in   = 1'b1;
                  cnt_in   = cnt_ff + CW'(1);
                  state_in = S_TAIL;
               end else if (out_free) begin
                  out_valid_in    = 1'b1;
                  out_offset_in   = OW'(cnt_ff);
                  out_run_end_in  = 1'b0;
                  out_overflow_in = step_ovf_ff;
                  nb_in           = nb_ff + NW'(1);
                  nbfr_in         = nbfr_ff + br;
                  emitted_in      = 1'b1;
               end
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = item_ff.fin ? S_HIGH : S_TAIL;
            end
         end
         S_HIGH: begin
            // Remaining entries up to the end of the row span
            if (high_go) begin
               if (nb_ff > NW'(rbno_pkg::MAX_BLOCKS)) begin
                  ovf_in   = 1'b1;
                  state_in = S_TAIL;
               end else if (out_free) begin
                  out_valid_in    = 1'b1;
                  out_offset_in   = OW'(cnt_ff);
                  out_run_end_in  = !step_ovf_ff && (nbfr_ff >= item_ff.span);
                  out_overflow_in = step_ovf_ff;
                  nb_in           = nb_ff + NW'(1);
                  nbfr_in         = nbfr_ff + br;
                  emitted_in      = 1'b1;
               end
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            // Drop a marker if overflow hit before any entry left
            if (ovf_ff && !emitted_ff) begin
               if (out_free) begin
                  out_valid_in    = 1'b1;
                  out_offset_in   = '0;
                  out_run_end_in  = 1'b0;
                  out_overflow_in = 1'b1;
                  emitted_in      = 1'b1;
                  finish          = item_ff.fin;
                  state_in        = S_IDLE;
               end
            end else begin
               finish   = item_ff.fin;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Clear the run after its final nonzero
      if (finish) begin
         cnt_in      = '0;
         nb_in       = '0;
         nbfr_in     = '0;
         ovf_in      = 1'b0;
         bound_ok_in = 1'b0;
      end

      if (cfg.block_rows_written) begin
         bound_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         nb_ff        <= '0;
         nbfr_ff      <= '0;
         ovf_ff       <= 1'b0;
         bound_ok_ff  <= 1'b0;
         step_ovf_ff  <= 1'b0;
         emitted_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nb_ff        <= nb_in;
         nbfr_ff      <= nbfr_in;
         ovf_ff       <= ovf_in;
         bound_ok_ff  <= bound_ok_in;
         step_ovf_ff  <= step_ovf_in;
         emitted_ff   <= emitted_in;
         out_valid_ff <= out_valid_in;
      end
      bound_ff        <= bound_in;
      item_ff         <= item_in;
      out_offset_ff   <= out_offset_in;
      out_run_end_ff  <= out_run_end_in;
      out_overflow_ff <= out_overflow_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.block_offset = out_offset_ff;
   assign rsp_ch.run_end      = out_run_end_ff;
   assign rsp_ch.overflow     = out_overflow_ff;

   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      nb_ff <= NW'(rbno_pkg::MAX_BLOCKS + 1))
      else $error("entry index beyond overflow limit");

   a_end_not_overflow: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_run_end_ff) |-> !out_overflow_ff)
      else $error("run end flagged on an overflowed list");

   a_bound_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> bound_ok_ff)
      else $error("stepping with a stale overflow boundary");

   a_predict_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL) |-> (ovf_ff == step_ovf_ff))
      else $error("overflow prediction differs from stepped result");

endmodule

/* design/row_block_nonzero_offsets_top.sv */
// Top level of the row block nonzero offset builder: register file, front, queue, back.
// Depends on rbno_pkg, rbno_if, rbno_front, rbno_queue, rbno_back.
// Throughput: one non-final nonzero per cycle while rows stay in the current block and the
// overflow limit is current; a final nonzero or a crossing one holds the back end in its
// low, high (final only) and tail states. A first entry passes the queue, the low state and
// the output register; a block_rows write or a run end first refreshes the overflow limit.
// Reset: block_rows and row_count return to 1, count and block state clear, queue empties.

module row_block_nonzero_offsets_top (
   input  logic         clock,
   input  logic         reset,
   rbno_req_if.sink     req_ch,
   rbno_rsp_if.source   rsp_ch,
   rbno_csr_if.sink     csr_ch
);

   logic [rbno_pkg::BLOCK_ROWS_WIDTH-1:0] block_rows_ff;
   logic [rbno_pkg::ROW_COUNT_WIDTH-1:0]  row_count_ff;
   rbno_pkg::cfg_type                     cfg;
   logic                                  q_push;
   logic                                  q_full;
   logic                                  q_pop;
   logic                                  q_not_empty;
   rbno_pkg::item_type                    q_item;
   rbno_pkg::item_type                    q_head;

   // Register writes are taken at once
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_rows_ff <= rbno_pkg::BLOCK_ROWS_WIDTH'(1);
         row_count_ff  <= rbno_pkg::ROW_COUNT_WIDTH'(1);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            rbno_pkg::CSR_BLOCK_ROWS: block_rows_ff <= rbno_pkg::BLOCK_ROWS_WIDTH'(csr_ch.data);
            rbno_pkg::CSR_ROW_COUNT:  row_count_ff  <= rbno_pkg::ROW_COUNT_WIDTH'(csr_ch.data);
            default: ;
         endcase
      end
   end

   // A block size of zero acts as one
   assign cfg.block_rows = (block_rows_ff == '0) ? rbno_pkg::BLOCK_ROWS_WIDTH'(1)
                                                 : block_rows_ff;
   assign cfg.row_count  = row_count_ff;
   assign cfg.block_rows_written = csr_ch.valid && (csr_ch.index == rbno_pkg::CSR_BLOCK_ROWS);

   rbno_front u_front (
      .req_ch (req_ch),
      .cfg    (cfg),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (q_item)
   );

   rbno_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rbno_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

/* sim/rbno_offset_checker.sv */
// Offset checker of the row block nonzero offset builder: snoops all three channels,
// predicts the block offsets of every accepted nonzero and compares each result beat.
// Depends on rbno_pkg and rbno_if.
`timescale 1ns / 1ps

module rbno_offset_checker (
   input  logic clock,
   input  logic reset,
   rbno_req_if  req_ch,
   rbno_rsp_if  rsp_ch,
   rbno_csr_if  csr_ch,
   output int   mismatch_count,
   output int   outstanding
);

   typedef struct packed {
      logic [rbno_pkg::OFFSET_WIDTH-1:0] block_offset;
      logic                              run_end;
      logic                              overflow;
   } offset_entry_type;

   // Register copies and per sub-matrix state
   logic [rbno_pkg::BLOCK_ROWS_WIDTH-1:0] block_rows_q;
   logic [rbno_pkg::ROW_COUNT_WIDTH-1:0]  row_count_q;
   logic [rbno_pkg::COUNT_WIDTH-1:0]      nonzeros_seen;
   int                                    next_entry;
   longint unsigned                       entry_first_row;
   bit                                    overflowed;

   offset_entry_type expected_offsets[$];

   task automatic report_mismatch(input string what,
                                  input logic [rbno_pkg::OFFSET_WIDTH-1:0] got,
                                  input logic [rbno_pkg::OFFSET_WIDTH-1:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_matrix();
      nonzeros_seen   = '0;
      next_entry      = 0;
      entry_first_row = 0;
      overflowed      = 1'b0;
   endtask

   // Work out the offset entries that one nonzero releases and queue them
   task automatic predict_offsets(input logic [rbno_pkg::ROW_INDEX_WIDTH-1:0] row_index,
                                  input logic final_nonzero);
      logic [rbno_pkg::OFFSET_WIDTH-1:0] offsets [rbno_pkg::MAX_BLOCKS+2];
      longint unsigned                   rows_per_block;
      longint unsigned                   row;
      longint unsigned                   span;
      bit                                was_overflowed;
      int                                n;
      offset_entry_type                  entry;
      rows_per_block = (block_rows_q == '0) ? 1 : block_rows_q;
      row            = row_index;
      was_overflowed = overflowed;
      n              = 0;

      // Emit every entry whose boundary this row has reached, counted before this nonzero
      while (!overflowed && row >= entry_first_row) begin
         if (next_entry > rbno_pkg::MAX_BLOCKS) begin
            overflowed = 1'b1;
            break;
         end
         offsets[n] = rbno_pkg::OFFSET_WIDTH'(nonzeros_seen);
         n++;
         next_entry++;
         entry_first_row += rows_per_block;
      end

      nonzeros_seen++;

      // Close out the row span on the last nonzero: entry k while block k-1 starts inside it
      if (final_nonzero && !overflowed) begin
         span = (row_count_q > row + 1) ? row_count_q : row + 1;
         while (entry_first_row >= rows_per_block && entry_first_row - rows_per_block < span)
         begin
            if (next_entry > rbno_pkg::MAX_BLOCKS) begin
               overflowed = 1'b1;
               break;
            end
            offsets[n] = rbno_pkg::OFFSET_WIDTH'(nonzeros_seen);
            n++;
            next_entry++;
            entry_first_row += rows_per_block;
         end
      end

      // A fresh overflow with nothing emitted still leaves one marker beat
      if (overflowed && n == 0 && !was_overflowed) begin
         offsets[0] = '0;
         n = 1;
      end

      for (int i = 0; i < n; i++) begin
         entry.block_offset = offsets[i];
         entry.run_end      = final_nonzero && !overflowed && (i == n - 1);
         entry.overflow     = overflowed;
         expected_offsets.insert(expected_offsets.size(), entry);
      end

      if (final_nonzero)
         clear_matrix();
   endtask

   // Snoop register writes and input beats, then check result beats in order
   always @(posedge clock) begin : watch
      offset_entry_type want;
      if (reset) begin
         block_rows_q   = rbno_pkg::BLOCK_ROWS_WIDTH'(1);
         row_count_q    = rbno_pkg::ROW_COUNT_WIDTH'(1);
         mismatch_count = 0;
         clear_matrix();
         expected_offsets.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               rbno_pkg::CSR_BLOCK_ROWS:
                  block_rows_q = csr_ch.data[rbno_pkg::BLOCK_ROWS_WIDTH-1:0];
               rbno_pkg::CSR_ROW_COUNT:
                  row_count_q  = csr_ch.data[rbno_pkg::ROW_COUNT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            predict_offsets(req_ch.row_index, req_ch.final_nonzero);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_offsets.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_ch.block_offset, '0);
            end else begin
               want = expected_offsets.pop_front();
               if (rsp_ch.block_offset !== want.block_offset)
                  report_mismatch("block_offset", rsp_ch.block_offset, want.block_offset);
               if (rsp_ch.run_end !== want.run_end)
                  report_mismatch("run_end", rbno_pkg::OFFSET_WIDTH'(rsp_ch.run_end),
                                  rbno_pkg::OFFSET_WIDTH'(want.run_end));
               if (rsp_ch.overflow !== want.overflow)
                  report_mismatch("overflow", rbno_pkg::OFFSET_WIDTH'(rsp_ch.overflow),
                                  rbno_pkg::OFFSET_WIDTH'(want.overflow));
            end
         end
      end
      outstanding <= expected_offsets.size();
   end

endmodule

/* sim/tb_row_block_nonzero_offsets_top.sv */
// Testbench top of the row block nonzero offset builder: clock, reset, register writes,
// nonzero stimulus and result back-pressure; rbno_offset_checker does the predicting.
// Depends on rbno_pkg, rbno_if, rbno_offset_checker and row_block_nonzero_offsets_top.
`timescale 1ns / 1ps

module tb_row_block_nonzero_offsets_top;

   localparam int MAX_ROW        = 2**rbno_pkg::ROW_INDEX_WIDTH - 1;
   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int PHASE_BEATS    = 54;
   localparam int SWAP_IDLE_AT   = 150;
   localparam int NO_IDLE_AT     = 300;
   localparam int HOLD_AT        = 340;
   localparam int HOLD_CYCLES    = 400;

   localparam logic [rbno_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rbno_req_if req_ch ();
   rbno_rsp_if rsp_ch ();
   rbno_csr_if csr_ch ();

   int offset_errors;
   int offsets_pending;

   int  beats_sent = 0;
   int  sender_idle_pct = 18;
   int  receiver_idle_pct = 85;
   bit  hold_request = 1'b0;
   int  cycle_count = 0;

   logic [rbno_pkg::BLOCK_ROWS_WIDTH-1:0] block_rows_now = rbno_pkg::BLOCK_ROWS_WIDTH'(1);

   row_block_nonzero_offsets_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   rbno_offset_checker offset_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (offset_errors),
      .outstanding    (offsets_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result back-pressure: random stalls, plus one long hold-off counted here
   always @(posedge clock) begin : receiver
      int  hold_left;
      bit  hold_taken;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Offer one nonzero beat and wait for it to be taken; valid stays high afterwards
   task automatic send_nonzero(input int row, input bit last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.row_index     <= rbno_pkg::ROW_INDEX_WIDTH'(row);
      req_ch.final_nonzero <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
      // Swap the idling of the two sides, then drop idling altogether
      if (beats_sent == SWAP_IDLE_AT) begin
         sender_idle_pct = 85;
         receiver_idle_pct <= 18;
      end
      if (beats_sent == NO_IDLE_AT) begin
         sender_idle_pct = 0;
         receiver_idle_pct <= 0;
      end
      if (beats_sent == HOLD_AT)
         hold_request <= 1'b1;
   endtask

   // Stop offering and wait until every expected offset is back and the pipe is empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (offsets_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register beat; valid is left high for a following write
   task automatic write_reg(input logic [rbno_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [rbno_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic configure(input logic [rbno_pkg::CSR_DATA_WIDTH-1:0] rows_per_block,
                            input logic [rbno_pkg::CSR_DATA_WIDTH-1:0] rows_total);
      drain();
      write_reg(rbno_pkg::CSR_BLOCK_ROWS, rows_per_block);
      write_reg(rbno_pkg::CSR_ROW_COUNT, rows_total);
      csr_ch.valid <= 1'b0;
      block_rows_now = rows_per_block[rbno_pkg::BLOCK_ROWS_WIDTH-1:0];
   endtask

   // One sub-matrix: random row steps, no drop unless shuffled, mostly under the block limit
   task automatic random_run();
      int rows_per_block;
      int row_limit;
      int beats;
      int row;
      bit shuffled;
      rows_per_block = (block_rows_now == '0) ? 1 : int'(block_rows_now);
      row_limit = rbno_pkg::MAX_BLOCKS * rows_per_block - 1;
      if (row_limit > MAX_ROW || $urandom_range(7) == 0)
         row_limit = MAX_ROW;
      shuffled = ($urandom_range(9) == 0);
      beats = $urandom_range(1, 10);
      row = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(0, row_limit / 4));
      for (int i = 0; i < beats; i++) begin
         send_nonzero(row, i == beats - 1);
         case ($urandom_range(9)) inside
            [0:3]:   ;
            [4:7]:   row += $urandom_range(0, row_limit / beats + 1);
            8:       row += $urandom_range(0, row_limit);
            default: row = shuffled ? row - int'($urandom_range(0, row)) : row + 1;
         endcase
         if (row > row_limit)
            row = row_limit;
      end
   endtask

   task automatic random_phase(input logic [rbno_pkg::CSR_DATA_WIDTH-1:0] rows_per_block,
                               input logic [rbno_pkg::CSR_DATA_WIDTH-1:0] rows_total);
      int start;
      configure(rows_per_block, rows_total);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS)
         random_run();
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.row_index     = '0;
      req_ch.final_nonzero = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: one block per row, one row
      send_nonzero(0, 1'b1);                 // single nonzero sub-matrix
      send_nonzero(0, 1'b0);
      send_nonzero(0, 1'b0);
      send_nonzero(2, 1'b0);                 // skips an empty block
      send_nonzero(1, 1'b0);                 // row out of order
      send_nonzero(5, 1'b1);
      send_nonzero(63, 1'b0);                // every entry at once
      send_nonzero(64, 1'b0);                // one block too many: marker only
      send_nonzero(70, 1'b1);                // silent after overflow
      send_nonzero(MAX_ROW, 1'b1);           // overflow on the very first nonzero

      // Zero block size and zero row count
      configure('0, '0);
      send_nonzero(5, 1'b1);
      send_nonzero(0, 1'b1);

      // Largest block size and row count, plus a write to an unmapped index
      configure(rbno_pkg::CSR_DATA_WIDTH'(16'hFFFF), rbno_pkg::CSR_DATA_WIDTH'(21'h1F_FFFF));
      write_reg(CSR_UNMAPPED, '1);
      csr_ch.valid <= 1'b0;
      send_nonzero(0, 1'b0);
      send_nonzero(MAX_ROW, 1'b0);
      send_nonzero(MAX_ROW, 1'b1);
      send_nonzero(0, 1'b1);

      // Random sub-matrices under a range of settings
      random_phase(4, 100);
      random_phase(1, 63);
      random_phase(7, 300);
      random_phase(65535, 2097151);
      random_phase(20000, 1048576);
      random_phase(32'h5A5A_0003, 1);        // upper data bits must be ignored
      random_phase(0, 0);

      drain();
      if (offset_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
